### hdl/mck_pkg.sv
// shared types, constants and code rom for the morse character keyer
package mck_pkg;

  localparam int CodeW = 16;

  localparam logic [7:0] FirstCode = 8'h20;
  localparam logic [7:0] LastCode  = 8'h5A;
  localparam logic [7:0] LowerA    = 8'h61;
  localparam logic [7:0] LowerZ    = 8'h7A;
  localparam logic [7:0] CaseFold  = 8'h20;

  localparam logic [1:0] SymEnd  = 2'b00;
  localparam logic [1:0] SymDot  = 2'b01;
  localparam logic [1:0] SymDash = 2'b11;

  localparam logic [2:0] DotUnits  = 3'd1;
  localparam logic [2:0] DashUnits = 3'd3;
  localparam logic [2:0] TailUnits = 3'd3;
  localparam logic [2:0] EmptyUnits = 3'd4;

  typedef logic [CodeW-1:0] code_t;

  typedef struct packed {
    logic  valid;
    code_t code;
  } mck_word_t;

  function automatic code_t code_rom(input logic [5:0] idx);
    code_t w;
    case (idx)
      6'd1:  w = 16'hDDF0;
      6'd2:  w = 16'h75D0;
      6'd4:  w = 16'h575C;
      6'd6:  w = 16'h7540;
      6'd7:  w = 16'h7FD0;
      6'd8:  w = 16'hDF40;
      6'd9:  w = 16'hDF70;
      6'd11: w = 16'h7740;
      6'd12: w = 16'hF5F0;
      6'd13: w = 16'hD570;
      6'd14: w = 16'h7770;
      6'd15: w = 16'hD740;
      6'd16: w = 16'hFFC0;
      6'd17: w = 16'h7FC0;
      6'd18: w = 16'h5FC0;
      6'd19: w = 16'h57C0;
      6'd20: w = 16'h55C0;
      6'd21: w = 16'h5540;
      6'd22: w = 16'hD540;
      6'd23: w = 16'hF540;
      6'd24: w = 16'hFD40;
      6'd25: w = 16'hFF40;
      6'd26: w = 16'hFD50;
      6'd27: w = 16'hDDD0;
      6'd29: w = 16'hD5C0;
      6'd31: w = 16'h5F50;
      6'd32: w = 16'h7DD0;
      6'd33: w = 16'h7000;
      6'd34: w = 16'hD500;
      6'd35: w = 16'hDD00;
      6'd36: w = 16'hD400;
      6'd37: w = 16'h4000;
      6'd38: w = 16'h5D00;
      6'd39: w = 16'hF400;
      6'd40: w = 16'h5500;
      6'd41: w = 16'h5000;
      6'd42: w = 16'h7F00;
      6'd43: w = 16'hDC00;
      6'd44: w = 16'h7500;
      6'd45: w = 16'hF000;
      6'd46: w = 16'hD000;
      6'd47: w = 16'hFC00;
      6'd48: w = 16'h7D00;
      6'd49: w = 16'hF700;
      6'd50: w = 16'h7400;
      6'd51: w = 16'h5400;
      6'd52: w = 16'hC000;
      6'd53: w = 16'h5C00;
      6'd54: w = 16'h5700;
      6'd55: w = 16'h7C00;
      6'd56: w = 16'hD700;
      6'd57: w = 16'hDF00;
      6'd58: w = 16'hF500;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

### hdl/mck_encoder.sv
// input stage: case folding, range check and code rom lookup into a holding register
module mck_encoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_character,
  input  logic             take,
  output mck_pkg::mck_word_t word
);

  logic              valid_r, valid_nxt;
  mck_pkg::code_t    code_r, code_nxt;
  logic [7:0]        folded;
  logic [5:0]        offset;
  logic              in_range;
  logic              accept;

  always_comb begin
    folded = in_character;
    if (in_character >= mck_pkg::LowerA && in_character <= mck_pkg::LowerZ) begin
      folded = in_character - mck_pkg::CaseFold;
    end
    in_range = (folded >= mck_pkg::FirstCode) && (folded <= mck_pkg::LastCode);
    offset   = folded[5:0] - mck_pkg::FirstCode[5:0];
  end

  assign in_stall = valid_r & ~take;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    code_nxt  = code_r;
    if (take) begin
      valid_nxt = 1'b0;
    end
    if (accept && in_range) begin
      valid_nxt = 1'b1;
      code_nxt  = mck_pkg::code_rom(offset);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    code_r <= code_nxt;
  end

  assign word.valid = valid_r;
  assign word.code  = code_r;

endmodule

### hdl/mck_sequencer.sv
// unit sequencer: shifts the code word out two bits per symbol, one time unit per cycle unless out_stall holds it
module mck_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  mck_pkg::mck_word_t word,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_light_on,
  output logic               out_last_unit
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhOn   = 2'd1;
  localparam logic [1:0] PhGap  = 2'd2;
  localparam logic [1:0] PhTail = 2'd3;

  logic [1:0]     phase_r, phase_nxt;
  mck_pkg::code_t shift_r, shift_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           light_r, light_nxt;
  logic           last_r, last_nxt;
  logic           adv;
  logic           emit;
  logic           level;
  logic           fin;
  logic           do_load;
  mck_pkg::code_t shifted;

  assign adv     = ~out_valid_r | ~out_stall;
  assign shifted = {shift_r[mck_pkg::CodeW-3:0], mck_pkg::SymEnd};

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    level     = 1'b0;
    fin       = 1'b0;
    do_load   = 1'b0;
    if (adv) begin
      unique case (phase_r)
        PhIdle: begin
          do_load = word.valid;
          if (!word.valid) begin
            phase_nxt = PhIdle;
          end
        end
        PhOn: begin
          emit    = 1'b1;
          level   = 1'b1;
          cnt_nxt = cnt_r - 3'd1;
          if (cnt_r == 3'd1) begin
            phase_nxt = PhGap;
          end
        end
        PhGap: begin
          emit = 1'b1;
          if (shifted[mck_pkg::CodeW-1 -: 2] != mck_pkg::SymEnd) begin
            phase_nxt = PhOn;
            shift_nxt = shifted;
            cnt_nxt   = (shifted[mck_pkg::CodeW-1 -: 2] == mck_pkg::SymDash) ?
                        mck_pkg::DashUnits : mck_pkg::DotUnits;
          end else begin
            phase_nxt = PhTail;
            shift_nxt = '0;
            cnt_nxt   = mck_pkg::TailUnits;
          end
        end
        PhTail: begin
          emit    = 1'b1;
          cnt_nxt = cnt_r - 3'd1;
          if (cnt_r == 3'd1) begin
            fin       = 1'b1;
            phase_nxt = PhIdle;
            do_load   = word.valid;
          end
        end
        default: phase_nxt = PhIdle;
      endcase
    end
    if (do_load) begin
      if (word.code[mck_pkg::CodeW-1 -: 2] == mck_pkg::SymEnd) begin
        phase_nxt = PhTail;
        shift_nxt = '0;
        cnt_nxt   = mck_pkg::EmptyUnits;
      end else begin
        phase_nxt = PhOn;
        shift_nxt = word.code;
        cnt_nxt   = (word.code[mck_pkg::CodeW-1 -: 2] == mck_pkg::SymDash) ?
                    mck_pkg::DashUnits : mck_pkg::DotUnits;
      end
    end
  end

  assign take = do_load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    light_nxt     = light_r;
    last_nxt      = last_r;
    if (adv) begin
      out_valid_nxt = emit;
      if (emit) begin
        light_nxt = level;
        last_nxt  = fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PhIdle;
      cnt_r       <= '0;
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
    light_r <= light_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_light_on  = light_r;
  assign out_last_unit = last_r;

endmodule

### hdl/morse_character_keyer.sv
// top level of the morse character keyer
// Each accepted word is one ASCII character; the block sends it as Morse code,
// one result word per time unit: a dot is 1 unit on, a dash 3 units on, each
// symbol is followed by 1 unit off and each character by 3 more units off.
// Lowercase is folded to uppercase; codes outside space..'Z' and 128..255 are
// dropped and give no result. Characters without a code give 4 units off.
// out_last_unit marks the final unit of a character. A character has 4 to 23
// units, and the sequencer gives one unit per cycle unless out_stall holds the
// output; when it was idle, a load step without a result comes first. The next
// character waits in the input register and follows without a gap.
module morse_character_keyer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_light_on,
  output logic       out_last_unit
);

  mck_pkg::mck_word_t word;
  logic               take;

  mck_encoder u_encoder (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .take         (take),
    .word         (word)
  );

  mck_sequencer u_sequencer (
    .clk           (clk),
    .rst_n         (rst_n),
    .word          (word),
    .take          (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_light_on  (out_light_on),
    .out_last_unit (out_last_unit)
  );

endmodule
